// ===== sv/oprx_pkg.sv =====
`default_nettype none

package oprx_pkg;

	localparam int unsigned MAX_DIM = 32;
	localparam int unsigned DIM_W = 6;
	localparam int unsigned POS_W = 14;
	localparam int unsigned SCREEN_W = 16;
	localparam logic [7:0] OPAQUE_MIN = 8'd128;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] REG_CURSOR_X = 2'd0;
	localparam logic [1:0] REG_CURSOR_Y = 2'd1;
	localparam logic [1:0] REG_IMAGE_WIDTH = 2'd2;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0] cursor_x;
		logic [POS_W-1:0] cursor_y;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pix_t;

	typedef struct packed {
		logic signed [SCREEN_W-1:0] box_x;
		logic signed [SCREEN_W-1:0] box_y;
		logic [DIM_W-1:0] run_len;
		logic [23:0] run_rgb;
		logic last;
	} box_t;

	// up to two boxes written into the output queue in one cycle
	typedef struct packed {
		logic [1:0] count;
		box_t first;
		box_t second;
	} push_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		begin
			if (v == '0) begin
				r = DIM_W'(1);
			end else if (v > DIM_W'(MAX_DIM)) begin
				r = DIM_W'(MAX_DIM);
			end else begin
				r = v;
			end
			return r;
		end
	endfunction

endpackage

`default_nettype wire

// ===== sv/oprx_if.sv =====
`default_nettype none

interface oprx_pix_if;
	logic valid;
	logic ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;

	modport source (output valid, output red, output green, output blue, output alpha,
		input ready);
	modport sink (input valid, input red, input green, input blue, input alpha,
		output ready);
endinterface

interface oprx_box_if;
	logic valid;
	logic ready;
	logic signed [15:0] box_x;
	logic signed [15:0] box_y;
	logic [5:0] run_len;
	logic [23:0] run_rgb;
	logic last;

	modport source (output valid, output box_x, output box_y, output run_len,
		output run_rgb, output last, input ready);
	modport sink (input valid, input box_x, input box_y, input run_len,
		input run_rgb, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/oprx_runner.sv =====
`default_nettype none

module oprx_runner (
	input wire logic clk,
	input wire logic arst_n,
	input wire oprx_pkg::cfg_t cfg,
	oprx_pix_if.sink pixel,
	input wire logic room,
	output oprx_pkg::push_t push
);

	oprx_pkg::pix_t pix_s1;
	logic pix_vld_s1;

	logic [oprx_pkg::DIM_W-1:0] col_q;
	logic [oprx_pkg::DIM_W-1:0] row_q;
	logic open_q;
	logic [oprx_pkg::DIM_W-1:0] begin_q;
	logic [23:0] colour_q;

	logic fire;
	logic [oprx_pkg::DIM_W-1:0] w;
	logic [oprx_pkg::DIM_W-1:0] h;
	logic [oprx_pkg::SCREEN_W-1:0] base_x;
	logic [oprx_pkg::SCREEN_W-1:0] box_y;
	logic [23:0] rgb;
	logic opaque;
	logic same;
	logic cont;
	logic close1;
	logic new_run;
	logic [oprx_pkg::DIM_W-1:0] begin1;
	logic [23:0] colour1;
	logic row_end;
	logic close2;
	logic [oprx_pkg::DIM_W:0] end2;
	oprx_pkg::box_t b1;
	oprx_pkg::box_t b2;

	assign fire = pix_vld_s1 && room;
	assign pixel.ready = !pix_vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_vld_s1 <= 1'b0;
		end else if (pixel.ready) begin
			pix_vld_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.ready && pixel.valid) begin
			pix_s1 <= '{red: pixel.red, green: pixel.green, blue: pixel.blue,
				alpha: pixel.alpha};
		end
	end

	always_comb begin
		w = oprx_pkg::clamp_dim(cfg.image_width);
		h = oprx_pkg::clamp_dim(cfg.image_height);
		// image centred on the cursor, positions wrap to 16 bits
		base_x = oprx_pkg::SCREEN_W'(cfg.cursor_x) - oprx_pkg::SCREEN_W'(w[oprx_pkg::DIM_W-1:1]);
		box_y = oprx_pkg::SCREEN_W'(cfg.cursor_y) - oprx_pkg::SCREEN_W'(h[oprx_pkg::DIM_W-1:1])
			+ oprx_pkg::SCREEN_W'(row_q);

		rgb = {pix_s1.red, pix_s1.green, pix_s1.blue};
		opaque = pix_s1.alpha >= oprx_pkg::OPAQUE_MIN;
		same = open_q && (rgb == colour_q);
		cont = opaque && (!open_q || same);
		close1 = open_q && !cont;
		new_run = opaque && !same;
		begin1 = new_run ? col_q : begin_q;
		colour1 = new_run ? rgb : colour_q;
		row_end = col_q >= (w - oprx_pkg::DIM_W'(1));
		close2 = row_end && opaque;
		end2 = {1'b0, col_q} + (oprx_pkg::DIM_W+1)'(1);

		b1.box_x = $signed(base_x + oprx_pkg::SCREEN_W'(begin_q));
		b1.box_y = $signed(box_y);
		b1.run_len = col_q - begin_q;
		b1.run_rgb = colour_q;
		b1.last = !close2;

		b2.box_x = $signed(base_x + oprx_pkg::SCREEN_W'(begin1));
		b2.box_y = $signed(box_y);
		b2.run_len = oprx_pkg::DIM_W'(end2 - {1'b0, begin1});
		b2.run_rgb = colour1;
		b2.last = 1'b1;

		push.count = fire ? ({1'b0, close1} + {1'b0, close2}) : 2'd0;
		push.first = close1 ? b1 : b2;
		push.second = b2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			open_q <= 1'b0;
			begin_q <= '0;
			colour_q <= '0;
		end else if (fire) begin
			open_q <= opaque && !row_end;
			begin_q <= begin1;
			colour_q <= colour1;
			if (row_end) begin
				col_q <= '0;
				row_q <= (row_q >= (h - oprx_pkg::DIM_W'(1))) ? '0 : row_q + oprx_pkg::DIM_W'(1);
			end else begin
				col_q <= col_q + oprx_pkg::DIM_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/oprx_box_fifo.sv =====
`default_nettype none

module oprx_box_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire oprx_pkg::push_t push,
	output logic room,
	oprx_box_if.source box
);

	oprx_pkg::box_t mem_q [oprx_pkg::FIFO_DEPTH];
	logic [oprx_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [oprx_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [oprx_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic pop;
	logic [oprx_pkg::FIFO_PTR_W-1:0] wr_next;
	oprx_pkg::box_t head;

	// a pixel may write two boxes, so keep two entries free
	assign room = cnt_q <= oprx_pkg::FIFO_CNT_W'(oprx_pkg::FIFO_DEPTH - 2);
	assign pop = box.valid && box.ready;
	assign wr_next = wr_ptr_q + oprx_pkg::FIFO_PTR_W'(1);
	assign head = mem_q[rd_ptr_q];

	assign box.valid = cnt_q != '0;
	assign box.box_x = head.box_x;
	assign box.box_y = head.box_y;
	assign box.run_len = head.run_len;
	assign box.run_rgb = head.run_rgb;
	assign box.last = head.last;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + oprx_pkg::FIFO_PTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + oprx_pkg::FIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + oprx_pkg::FIFO_CNT_W'(push.count)
				- oprx_pkg::FIFO_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== sv/opaque_pixel_run_extractor_top.sv =====
// channel   | dir | payload                                  | handshake
// pixel     | in  | red, green, blue, alpha (8 bits each)    | valid / ready
// box       | out | box_x, box_y, run_len, run_rgb, last     | valid / ready
// cfg       | in  | cfg_index (2), cfg_data (14)             | cfg_we, no wait
//
// one pixel per cycle while there is room: input register, then the run
// logic writes 0, 1 or 2 boxes into a 4-entry output queue in the same
// cycle, and each box is held in that queue before it is output
// a pixel ending a row with a colour change writes two boxes; output
// drains one box per ready cycle; pixel.ready drops while more than 2 wait
// async reset clears counters, open run and queue; config resets to 0,0,32,32
`default_nettype none

module opaque_pixel_run_extractor_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [13:0] cfg_data,
	oprx_pix_if.sink pixel,
	oprx_box_if.source box
);

	oprx_pkg::cfg_t cfg_q;
	oprx_pkg::push_t push;
	logic room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cursor_x <= '0;
			cfg_q.cursor_y <= '0;
			cfg_q.image_width <= oprx_pkg::DIM_W'(oprx_pkg::MAX_DIM);
			cfg_q.image_height <= oprx_pkg::DIM_W'(oprx_pkg::MAX_DIM);
		end else if (cfg_we) begin
			case (cfg_index)
				oprx_pkg::REG_CURSOR_X: cfg_q.cursor_x <= cfg_data;
				oprx_pkg::REG_CURSOR_Y: cfg_q.cursor_y <= cfg_data;
				oprx_pkg::REG_IMAGE_WIDTH: cfg_q.image_width <= cfg_data[oprx_pkg::DIM_W-1:0];
				oprx_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[oprx_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	oprx_runner u_runner (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pixel(pixel),
		.room(room),
		.push(push)
	);

	oprx_box_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.box(box)
	);

endmodule

`default_nettype wire

// ===== sv/oprx_checker.sv =====
`default_nettype none

module oprx_props (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic box_valid,
	input wire logic box_ready,
	input wire logic signed [15:0] box_x,
	input wire logic signed [15:0] box_y,
	input wire logic [5:0] run_len,
	input wire logic [23:0] run_rgb,
	input wire logic last
);

	// a held box keeps its payload
	a_box_hold: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && !box_ready |=> box_valid
		&& $stable(box_x) && $stable(box_y) && $stable(run_len)
		&& $stable(run_rgb) && $stable(last))
		else $error("box payload changed while stalled");

	// every run covers one to a full row of pixels
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |-> run_len != 6'd0 && run_len <= 6'd32)
		else $error("run length out of range");

	// the partner of a box not marked last is already queued
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && box_ready && !last |=> box_valid)
		else $error("second box of a pixel missing");

endmodule

bind opaque_pixel_run_extractor_top oprx_props u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.box_valid(box.valid),
	.box_ready(box.ready),
	.box_x(box.box_x),
	.box_y(box.box_y),
	.run_len(box.run_len),
	.run_rgb(box.run_rgb),
	.last(box.last)
);

`default_nettype wire

// ===== sim/oprx_checker.sv =====
`default_nettype none

module oprx_checker
	import oprx_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [13:0] cfg_data,
	oprx_pix_if pixel,
	oprx_box_if box,
	output int unsigned fail_count,
	output int unsigned boxes_due
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t regs;
	logic [DIM_W-1:0] next_col;
	logic [DIM_W-1:0] next_row;
	logic [DIM_W-1:0] open_begin;
	logic run_active;
	logic [23:0] open_rgb;
	box_t boxes_q[$];
	int unsigned mismatches = 0;

	function automatic logic [DIM_W-1:0] usable_dim(input logic [DIM_W-1:0] v);
		return (v == '0) ? DIM_W'(1) : ((v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v);
	endfunction

	// box for the open run, closed just before column end_col
	function automatic box_t close_run(input logic [DIM_W:0] end_col);
		box_t b;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		w = usable_dim(regs.image_width);
		h = usable_dim(regs.image_height);
		b.box_x = SCREEN_W'(regs.cursor_x) - SCREEN_W'(w >> 1) + SCREEN_W'(open_begin);
		b.box_y = SCREEN_W'(regs.cursor_y) - SCREEN_W'(h >> 1) + SCREEN_W'(next_row);
		b.run_len = DIM_W'(end_col - {1'b0, open_begin});
		b.run_rgb = open_rgb;
		b.last = 1'b0;
		return b;
	endfunction

	task automatic extract_runs(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [7:0] a);
		logic [23:0] rgb;
		logic opaque;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] col;
		box_t found[2];
		int n;
		rgb = {r, g, b};
		opaque = (a >= OPAQUE_MIN);
		w = usable_dim(regs.image_width);
		h = usable_dim(regs.image_height);
		col = next_col;
		n = 0;
		if (opaque && (!run_active || rgb == open_rgb)) begin
			if (!run_active) begin
				run_active = 1'b1;
				open_begin = col;
				open_rgb = rgb;
			end
		end else begin
			if (run_active) begin
				found[n] = close_run({1'b0, col});
				n++;
				run_active = 1'b0;
			end
			if (opaque) begin
				run_active = 1'b1;
				open_begin = col;
				open_rgb = rgb;
			end
		end
		// a counter left beyond a shrunken width still ends the row here
		if (col >= w - 1) begin
			if (run_active) begin
				found[n] = close_run({1'b0, col} + 1'b1);
				n++;
				run_active = 1'b0;
			end
			next_col = '0;
			next_row = (next_row >= h - 1) ? '0 : next_row + 1'b1;
		end else begin
			next_col = col + 1'b1;
		end
		if (n > 0)
			found[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			boxes_q.push_back(found[i]);
	endtask

	task automatic check_box(input box_t got);
		box_t want;
		if (boxes_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected box: x %0d y %0d len %0d rgb %06h last %0b",
					got.box_x, got.box_y, got.run_len, got.run_rgb, got.last);
		end else begin
			want = boxes_q.pop_front();
			if (got.box_x !== want.box_x || got.box_y !== want.box_y
					|| got.run_len !== want.run_len || got.run_rgb !== want.run_rgb
					|| got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"box mismatch (expected/actual): x %0d/%0d y %0d/%0d ",
						"len %0d/%0d rgb %06h/%06h last %0b/%0b"},
						want.box_x, got.box_x, want.box_y, got.box_y,
						want.run_len, got.run_len, want.run_rgb, got.run_rgb,
						want.last, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.cursor_x = '0;
			regs.cursor_y = '0;
			regs.image_width = DIM_W'(MAX_DIM);
			regs.image_height = DIM_W'(MAX_DIM);
			next_col = '0;
			next_row = '0;
			open_begin = '0;
			run_active = 1'b0;
			open_rgb = '0;
			boxes_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CURSOR_X: regs.cursor_x = cfg_data[POS_W-1:0];
					REG_CURSOR_Y: regs.cursor_y = cfg_data[POS_W-1:0];
					REG_IMAGE_WIDTH: regs.image_width = cfg_data[DIM_W-1:0];
					REG_IMAGE_HEIGHT: regs.image_height = cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end
			if (pixel.valid && pixel.ready)
				extract_runs(pixel.red, pixel.green, pixel.blue, pixel.alpha);
			if (box.valid && box.ready)
				check_box({box.box_x, box.box_y, box.run_len, box.run_rgb, box.last});
		end
		fail_count <= mismatches;
		boxes_due <= boxes_q.size();
	end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import oprx_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned PHASES = 12;
	localparam int unsigned PHASE_ITEMS = 150;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [13:0] cfg_data;
	int unsigned fail_count;
	int unsigned boxes_due;
	int unsigned cycles = 0;

	// idling knobs, zero odds means no idling on that side
	bit calm = 1'b0;
	int unsigned gap_odds = 6;
	int unsigned stall_odds = 10;

	oprx_pix_if pixel_ch();
	oprx_box_if box_ch();

	opaque_pixel_run_extractor_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel(pixel_ch),
		.box(box_ch)
	);

	oprx_checker watch (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel(pixel_ch),
		.box(box_ch),
		.fail_count(fail_count),
		.boxes_due(boxes_due)
	);

	always #5ns clk = ~clk;

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// box receiver: ready low in random bursts
	initial begin
		box_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				box_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			box_ch.ready <= 1'b1;
		end
	end

	task automatic push_pixel(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic [7:0] a);
		if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			pixel_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		pixel_ch.valid <= 1'b1;
		pixel_ch.red <= r;
		pixel_ch.green <= g;
		pixel_ch.blue <= b;
		pixel_ch.alpha <= a;
		@(posedge clk);
		while (!pixel_ch.ready) @(posedge clk);
	endtask

	// stop sending, wait for every box, then let the input register empty
	task automatic settle();
		pixel_ch.valid <= 1'b0;
		@(posedge clk);
		while (boxes_due != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_config(input logic [13:0] x, input logic [13:0] y,
		input logic [13:0] w, input logic [13:0] h);
		logic [1:0] codes[4];
		logic [13:0] vals[4];
		codes = '{REG_CURSOR_X, REG_CURSOR_Y, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT};
		vals = '{x, y, w, h};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= codes[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [13:0] pick_cursor();
		case ($urandom_range(0, 3))
			0: return 14'd0;
			1: return 14'h3FFF;
			default: return 14'($urandom);
		endcase
	endfunction

	// mostly small images so rows end often
	function automatic logic [13:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return 14'd0;
			1: return 14'd32;
			2: return 14'($urandom_range(33, 63));
			3: return 14'($urandom_range(9, 31));
			default: return 14'($urandom_range(1, 8));
		endcase
	endfunction

	initial begin
		int pick;
		logic [23:0] palette[3];
		logic [23:0] current_rgb;
		logic [23:0] rgb;
		logic [7:0] alpha;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_CURSOR_X;
		cfg_data <= '0;
		pixel_ch.valid <= 1'b0;
		pixel_ch.red <= '0;
		pixel_ch.green <= '0;
		pixel_ch.blue <= '0;
		pixel_ch.alpha <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: position goes below zero
		push_pixel(8'h12, 8'h34, 8'h56, 8'hFF);
		push_pixel(8'h12, 8'h34, 8'h56, 8'h80);
		push_pixel(8'h00, 8'h00, 8'h00, 8'h7F);
		settle();

		// column counter sits on the last column of the new width
		write_config(14'h3FFF, 14'd0, 14'd4, 14'd2);
		push_pixel(8'h00, 8'h00, 8'h00, 8'h00);
		push_pixel(8'hFF, 8'h00, 8'h00, 8'h80);
		push_pixel(8'hFF, 8'h00, 8'h00, 8'hFF);
		// transparent pixel of the run colour still closes it
		push_pixel(8'hFF, 8'h00, 8'h00, 8'h7F);
		push_pixel(8'h00, 8'hFF, 8'h00, 8'hC8);
		push_pixel(8'h00, 8'h00, 8'hFF, 8'h80);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 8'h90);
		// colour change on the row end gives two boxes
		push_pixel(8'h00, 8'h00, 8'h00, 8'h80);
		push_pixel(8'hAA, 8'hAA, 8'hAA, 8'hC0);
		settle();

		// zero sizes act as one, with a run still open
		write_config(14'h2AAA, 14'h1555, 14'd0, 14'd0);
		push_pixel(8'h55, 8'h55, 8'h55, 8'h80);
		push_pixel(8'h01, 8'h02, 8'h03, 8'hFF);
		settle();

		// oversized dimensions saturate
		write_config(14'd0, 14'h3FFF, 14'd63, 14'd63);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 8'h80);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hA5);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			calm = (phase == PHASES - 1);
			case ($urandom_range(0, 3))
				0: gap_odds = 0;
				1: gap_odds = 3;
				default: gap_odds = 8;
			endcase
			case ($urandom_range(0, 3))
				0: stall_odds = 0;
				1: stall_odds = 4;
				default: stall_odds = 12;
			endcase
			write_config(pick_cursor(), pick_cursor(), pick_dim(), pick_dim());
			for (int c = 0; c < 3; c++)
				palette[c] = 24'($urandom);
			current_rgb = palette[0];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				alpha = ($urandom_range(0, 7) == 0) ? 8'h80 : 8'($urandom_range(128, 255));
				if (pick < 55) begin
					rgb = current_rgb;
				end else if (pick < 80) begin
					current_rgb = palette[$urandom_range(0, 2)];
					rgb = current_rgb;
				end else if (pick < 95) begin
					rgb = $urandom_range(0, 1) ? current_rgb : 24'($urandom);
					alpha = ($urandom_range(0, 7) == 0) ? 8'h7F : 8'($urandom_range(0, 127));
				end else begin
					rgb = 24'($urandom);
					alpha = 8'($urandom);
				end
				push_pixel(rgb[23:16], rgb[15:8], rgb[7:0], alpha);
			end
		end

		pixel_ch.valid <= 1'b0;
		@(posedge clk);
		while (boxes_due != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && boxes_due == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

// ===== opaque_pixel_run_extractor_top.f =====
sv/oprx_pkg.sv
sv/oprx_if.sv
sv/oprx_runner.sv
sv/oprx_box_fifo.sv
sv/opaque_pixel_run_extractor_top.sv
sv/oprx_checker.sv
sim/oprx_checker.sv
sim/tb.sv
